/* rtl/core/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// rbd_pkg: shared definitions for the ring buffer deque
// Field widths, operation and status codes, and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Payload field widths.
  localparam int MODE_W   = 2;
  localparam int CARD_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;

  // Requested operation carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Operation decided by the controller for the datapath.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_POP_FRONT    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_BACK     = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH_BACK    = 3'd3;
  localparam logic [OP_W-1:0] OP_REJECT_EMPTY = 3'd4;
  localparam logic [OP_W-1:0] OP_REJECT_FULL  = 3'd5;

  // Controller to datapath.
  typedef struct packed {
    logic            exec;      // execute op on the beat just accepted
    logic [OP_W-1:0] op;
    logic            load_out;  // move the pending result into the output register
  } rbd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic full;
  } rbd_stat_t;

endpackage

/* rtl/core/rbd_channels.sv */
// ----------------------------------------------------------------------------
// rbd_channels: request and response channels of the ring buffer deque
// Valid/ready channels; a beat moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface rbd_req_if import rbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CARD_W-1:0] card_in;

  modport source (output valid, output mode, output card_in, input ready);
  modport sink   (input valid, input mode, input card_in, output ready);
endinterface

interface rbd_rsp_if import rbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CARD_W-1:0]   card_out;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   fill_count;

  modport source (output valid, output card_out, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input card_out, input status, input fill_count,
                  output ready);
endinterface

/* rtl/core/ring_buffer_deque_top.sv */
// ----------------------------------------------------------------------------
// ring_buffer_deque_top: double-ended queue in a circular store
// Request beats carry a mode (pop front, pop back, push front, push back)
// and an element for pushes; each gives exactly one response beat with the
// popped element (zero otherwise), a status (ok, empty on pop, full on
// push) and the element count after the operation. A rejected operation
// leaves the queue unchanged.
// A request accepted at a rising edge reads or writes the store and fills
// the pending result, which moves to the response register in the result
// step when that register is free; the response is valid from the cycle
// after. The store has one registered read port, so each operation has an
// access step and a result step, and no request is taken in the result step.
// The next request is accepted while an earlier response still waits in
// the output register; if the receiver stalls, the following result waits
// inside the block and the request side holds ready low until it moves.
// Reset (synchronous, active high) empties the queue: head and count go to
// zero. Store contents are not cleared; only written entries are ever read.
// fill_count carries the low 7 bits of the count.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top import rbd_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  rbd_req_if.sink   req,
  rbd_rsp_if.source rsp
);

  rbd_cmd_t  cmd;
  rbd_stat_t stat;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .card_in    (req.card_in),
    .cmd        (cmd),
    .stat       (stat),
    .card_out   (rsp.card_out),
    .status     (rsp.status),
    .fill_count (rsp.fill_count)
  );

endmodule

/* rtl/core/rbd_datapath.sv */
// ----------------------------------------------------------------------------
// rbd_datapath: storage, indices and result register of the deque
// Holds the circular store, the head index and the element count, carries
// out the operation chosen by the controller and keeps the result beat.
// ----------------------------------------------------------------------------
module rbd_datapath import rbd_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CARD_W-1:0]   card_in,
  input  rbd_cmd_t            cmd,
  output rbd_stat_t           stat,
  output logic [CARD_W-1:0]   card_out,
  output logic [STATUS_W-1:0] status,
  output logic [FILL_W-1:0]   fill_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [AW-1:0]       head;
  logic [AW-1:0]       head_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CARD_W-1:0]   mem [DEPTH];
  logic [CARD_W-1:0]   rd_data;
  logic [AW-1:0]       addr;
  logic                wr_en;
  logic                rd_en;
  logic [AW-1:0]       offset;
  logic [AW:0]         sum_raw;
  logic [AW-1:0]       back_idx;
  logic [AW-1:0]       head_inc;
  logic [AW-1:0]       head_dec;
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]       res_count;
  logic                res_pop;

  // Index arithmetic: back entries sit at head plus an offset, wrapped once.
  always_comb begin
    offset   = (cmd.op == OP_POP_BACK) ? AW'(count - 1'b1) : AW'(count);
    sum_raw  = {1'b0, head} + {1'b0, offset};
    back_idx = (sum_raw >= DEPTH_EXT) ? AW'(sum_raw - DEPTH_EXT) : AW'(sum_raw);
    head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
    head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  end

  // Operation decode into store access and state update.
  always_comb begin
    head_next  = head;
    count_next = count;
    addr       = head;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    if (cmd.exec) begin
      case (cmd.op)
        OP_POP_FRONT: begin
          rd_en      = 1'b1;
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
        OP_POP_BACK: begin
          rd_en      = 1'b1;
          addr       = back_idx;
          count_next = count - 1'b1;
        end
        OP_PUSH_FRONT: begin
          wr_en      = 1'b1;
          addr       = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
        OP_PUSH_BACK: begin
          wr_en      = 1'b1;
          addr       = back_idx;
          count_next = count + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Head and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Circular store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= card_in;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  // Pending result while the store read completes.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_count <= count_next;
      res_pop   <= (cmd.op == OP_POP_FRONT) || (cmd.op == OP_POP_BACK);
      case (cmd.op)
        OP_REJECT_EMPTY: res_status <= STATUS_EMPTY;
        OP_REJECT_FULL:  res_status <= STATUS_FULL;
        default:         res_status <= STATUS_OK;
      endcase
    end
  end

  // Output register of the response channel.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      card_out   <= res_pop ? rd_data : '0;
      status     <= res_status;
      fill_count <= FILL_W'(res_count);
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == FULL_CNT);

  // The count never leaves its range and the head stays inside the store.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("element count beyond store depth");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= LAST_IDX)
    else $error("head index beyond store depth");

  // A successful push grows the count by exactly one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK)
    |=> count == $past(count) + 1'b1)
    else $error("push did not grow the count by one");

endmodule

/* rtl/core/rbd_ctrl.sv */
// ----------------------------------------------------------------------------
// rbd_ctrl: controller of the ring buffer deque
// Accepts one request beat at a time, chooses the operation from the mode
// and the empty and full flags, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rbd_ctrl import rbd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [MODE_W-1:0] req_mode,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  rbd_stat_t         stat,
  output rbd_cmd_t          cmd
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_RESULT = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;
  logic out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // Operation choice: a pop needs an element, a push needs a free entry.
  always_comb begin
    cmd.exec     = req_valid && req_ready;
    cmd.load_out = (state == S_RESULT) && out_free;
    case (req_mode)
      MODE_POP_FRONT:  cmd.op = stat.empty ? OP_REJECT_EMPTY : OP_POP_FRONT;
      MODE_POP_BACK:   cmd.op = stat.empty ? OP_REJECT_EMPTY : OP_POP_BACK;
      MODE_PUSH_FRONT: cmd.op = stat.full  ? OP_REJECT_FULL  : OP_PUSH_FRONT;
      MODE_PUSH_BACK:  cmd.op = stat.full  ? OP_REJECT_FULL  : OP_PUSH_BACK;
      default:         cmd.op = OP_REJECT_EMPTY;
    endcase
  end

  // Next state and output valid.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.exec) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (cmd.load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // An accepted beat always leads to the result step.
  a_exec_to_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> state == S_RESULT)
    else $error("accepted beat did not reach the result step");

  // A loaded result is offered on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid)
    else $error("loaded result not offered");

  // A result is never loaded over one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !rsp_valid || rsp_ready)
    else $error("result register overwritten before it was taken");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for ring_buffer_deque_top
// A scoreboard class holds its own model of the deque: the store, the head
// and the count. It predicts one response for every request beat that the
// block accepts. Each response beat is then compared field by field with the
// oldest prediction. A short directed sequence comes first. Random bursts
// follow; each burst leans towards pushes, towards pops, or neither. Both
// sides of the block stall at random, with three different mixes of stalls.
// ----------------------------------------------------------------------------
module tb import rbd_pkg::*; ();

  localparam int DEPTH       = 64;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int RANDOM_OPS  = 650;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  // Deque model and store of predicted responses.
  class deque_scoreboard;
    typedef struct packed {
      logic [CARD_W-1:0]   card;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill;
    } response_t;

    logic [CARD_W-1:0] cards [DEPTH];
    logic [IDX_W-1:0]  head;
    logic [FILL_W-1:0] held;
    response_t         expected_responses [$];
    int                mismatch_count;

    function new();
      head           = '0;
      held           = '0;
      mismatch_count = 0;
    endfunction

    // Apply one accepted request to the model and queue the response it gives.
    function void note_request(logic [MODE_W-1:0] mode, logic [CARD_W-1:0] card);
      response_t        want;
      logic [IDX_W-1:0] slot;
      want.card   = '0;
      want.status = STATUS_OK;
      case (mode)
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (held == 0) begin
            want.status = STATUS_EMPTY;
          end else begin
            if (mode == MODE_POP_FRONT) begin
              want.card = cards[head];
              head      = head + 1'b1;
            end else begin
              slot      = head + IDX_W'(held - 1'b1);
              want.card = cards[slot];
            end
            held = held - 1'b1;
          end
        end
        default: begin
          if (held == FILL_W'(DEPTH)) begin
            want.status = STATUS_FULL;
          end else begin
            if (mode == MODE_PUSH_FRONT) begin
              head        = head - 1'b1;
              cards[head] = card;
            end else begin
              slot        = head + IDX_W'(held);
              cards[slot] = card;
            end
            held = held + 1'b1;
          end
        end
      endcase
      want.fill = held;
      expected_responses.push_back(want);
    endfunction

    // Compare one response beat with the oldest prediction.
    function void check_response(logic [CARD_W-1:0] card, logic [STATUS_W-1:0] status,
                                 logic [FILL_W-1:0] fill);
      response_t want;
      if (expected_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected response: card %0d status %0d fill %0d",
                   card, status, fill);
      end else begin
        want = expected_responses.pop_front();
        if (card !== want.card || status !== want.status || fill !== want.fill) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: exp card %0d st %0d fill %0d, got card %0d st %0d fill %0d",
                     want.card, want.status, want.fill, card, status, fill);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   cycle_count = 0;

  deque_scoreboard sb = new();

  rbd_req_if req_ch ();
  rbd_rsp_if rsp_ch ();

  ring_buffer_deque_top #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ring_buffer_deque_top: FAILED **");
      $finish;
    end
  end

  // Response side: random back-pressure, changed on the falling edge.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Check every response beat as it is taken.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.card_out, rsp_ch.status, rsp_ch.fill_count);
  end

  // Drive one request beat, with a random idle gap ahead of it. Called and
  // left at a falling edge.
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [CARD_W-1:0] card);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= mode;
    req_ch.card_in <= card;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(mode, card);
    @(negedge clk);
  endtask

  // A run of random operations, pushes making up push_pct per cent of them.
  task automatic send_burst(input int len, input int push_pct);
    logic [MODE_W-1:0] mode;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < push_pct)
        mode = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      else
        mode = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
      send_op(mode, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int budget;
    int len;
    int push_pct;

    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.mode    = MODE_POP_FRONT;
    req_ch.card_in = '0;
    src_idle_pct   = 22;
    snk_idle_pct   = 80;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: pops on an empty deque, value extremes, head wrap below zero,
    // every operation, and back to empty.
    send_op(MODE_POP_FRONT,  8'h33);
    send_op(MODE_POP_BACK,   8'hCC);
    send_op(MODE_PUSH_FRONT, 8'h00);
    send_op(MODE_PUSH_BACK,  8'hFF);
    send_op(MODE_PUSH_FRONT, 8'hA5);
    send_op(MODE_POP_BACK,   8'h00);
    send_op(MODE_POP_FRONT,  8'hFF);
    send_op(MODE_POP_FRONT,  8'h00);
    send_op(MODE_POP_FRONT,  8'h00);
    send_op(MODE_PUSH_BACK,  8'h5A);
    send_op(MODE_POP_FRONT,  8'hFF);
    send_op(MODE_PUSH_BACK,  8'h01);
    send_op(MODE_PUSH_FRONT, 8'h80);
    send_op(MODE_POP_BACK,   8'h7F);
    send_op(MODE_POP_BACK,   8'hFE);
    send_op(MODE_POP_BACK,   8'h55);

    // Random bursts under three mixes of stalls.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 22;
          snk_idle_pct = 80;
        end
        1: begin
          src_idle_pct = 80;
          snk_idle_pct = 22;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      budget = RANDOM_OPS / 3;
      // Fill past full, then drain past empty, before the mixed bursts.
      if (phase == 0) begin
        send_burst(70, 100);
        send_burst(70, 0);
        budget -= 140;
      end
      while (budget > 0) begin
        len = $urandom_range(120, 40);
        if (len > budget)
          len = budget;
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        send_burst(len, push_pct);
        budget -= len;
      end
    end
    req_ch.valid <= 1'b0;

    // Let the remaining responses drain, then allow a short tail.
    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.expected_responses.size() == 0)
      $display("** ring_buffer_deque_top: PASSED **");
    else
      $display("** ring_buffer_deque_top: FAILED **");
    $finish;
  end

endmodule
